[rtl/ffpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared codes and control/status types for the first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int MAX_EXTENTS_DEF     = 64;
    localparam int PAGE_INDEX_BITS_DEF = 20;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE   = 4'd0;
    localparam op_t OP_LOAD   = 4'd1;
    localparam op_t OP_NEXT   = 4'd2;
    localparam op_t OP_RD_IDX = 4'd3;
    localparam op_t OP_RD_JM1 = 4'd4;
    localparam op_t OP_RD_JP1 = 4'd5;
    localparam op_t OP_SHINIT = 4'd6;
    localparam op_t OP_SHD    = 4'd7;
    localparam op_t OP_SHU    = 4'd8;
    localparam op_t OP_INS    = 4'd9;
    localparam op_t OP_AEV    = 4'd10;
    localparam op_t OP_REMEND = 4'd11;
    localparam op_t OP_MEV    = 4'd12;
    localparam op_t OP_MEND   = 4'd13;
    localparam op_t OP_FULL   = 4'd14;
    localparam op_t OP_NOFIT  = 4'd15;

    typedef struct packed {
        op_t op;
    } dp_ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       cnt_zero;
        logic       table_full;
        logic       over_free;
        logic       idx_end;
        logic       j_at_pos;
        logic       j_last;
        logic       hit;
        logic       exact;
        logic       kept_full;
    } dp_stat_t;

endpackage

[rtl/ffpa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Command sequencer: walks the extent table for add, allocate and free.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    input  ffpa_pkg::dp_stat_t stat,
    output ffpa_pkg::dp_ctl_t  ctl
);
    import ffpa_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_PRD    = 4'd2;
    localparam logic [3:0] S_PEV    = 4'd3;
    localparam logic [3:0] S_SHRD   = 4'd4;
    localparam logic [3:0] S_SHWR   = 4'd5;
    localparam logic [3:0] S_ARD    = 4'd6;
    localparam logic [3:0] S_AEV    = 4'd7;
    localparam logic [3:0] S_RRD    = 4'd8;
    localparam logic [3:0] S_RWR    = 4'd9;
    localparam logic [3:0] S_MRD    = 4'd10;
    localparam logic [3:0] S_MEV    = 4'd11;
    localparam logic [3:0] S_MEND   = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_FIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op     = OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.cnt_zero)
                begin
                    state_next = S_FIN;
                end
                else if (stat.cmd == CMD_ADD)
                begin
                    if (stat.table_full)
                    begin
                        ctl.op     = OP_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_PRD;
                    end
                end
                else if (stat.cmd == CMD_ALLOC)
                begin
                    if (stat.over_free)
                    begin
                        ctl.op     = OP_NOFIT;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_ARD;
                    end
                end
                else if (stat.cmd == CMD_FREE)
                begin
                    state_next = S_MRD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_PRD:
            begin
                if (stat.idx_end)
                begin
                    ctl.op     = OP_SHINIT;
                    state_next = S_SHRD;
                end
                else
                begin
                    ctl.op     = OP_RD_IDX;
                    state_next = S_PEV;
                end
            end
            S_PEV:
            begin
                if (stat.hit)
                begin
                    ctl.op     = OP_SHINIT;
                    state_next = S_SHRD;
                end
                else
                begin
                    ctl.op     = OP_NEXT;
                    state_next = S_PRD;
                end
            end
            S_SHRD:
            begin
                if (stat.j_at_pos)
                begin
                    ctl.op     = OP_INS;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.op     = OP_RD_JM1;
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                ctl.op     = OP_SHD;
                state_next = S_SHRD;
            end
            S_ARD:
            begin
                if (stat.idx_end)
                begin
                    ctl.op     = OP_NOFIT;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.op     = OP_RD_IDX;
                    state_next = S_AEV;
                end
            end
            S_AEV:
            begin
                ctl.op = OP_AEV;
                if (!stat.hit)
                begin
                    state_next = S_ARD;
                end
                else if (stat.exact)
                begin
                    state_next = S_RRD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_RRD:
            begin
                if (stat.j_last)
                begin
                    ctl.op     = OP_REMEND;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.op     = OP_RD_JP1;
                    state_next = S_RWR;
                end
            end
            S_RWR:
            begin
                ctl.op     = OP_SHU;
                state_next = S_RRD;
            end
            S_MRD:
            begin
                if (stat.idx_end)
                begin
                    state_next = S_MEND;
                end
                else
                begin
                    ctl.op     = OP_RD_IDX;
                    state_next = S_MEV;
                end
            end
            S_MEV:
            begin
                ctl.op     = OP_MEV;
                state_next = S_MRD;
            end
            S_MEND:
            begin
                if (stat.kept_full)
                begin
                    ctl.op     = OP_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.op     = OP_MEND;
                    state_next = S_PRD;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/ffpa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_dp
// Datapath: extent table memory, indexes, free count and result registers.
// ----------------------------------------------------------------------------
module ffpa_dp #(
    parameter int MAX_EXTENTS     = ffpa_pkg::MAX_EXTENTS_DEF,
    parameter int PAGE_INDEX_BITS = ffpa_pkg::PAGE_INDEX_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 cmd,
    input  logic [PAGE_INDEX_BITS-1:0] page_index,
    input  logic [PAGE_INDEX_BITS:0]   page_count,
    input  ffpa_pkg::dp_ctl_t          ctl,
    output ffpa_pkg::dp_stat_t         stat,
    output logic [1:0]                 status,
    output logic [PAGE_INDEX_BITS-1:0] block_start,
    output logic [PAGE_INDEX_BITS:0]   free_total
);
    import ffpa_pkg::*;

    localparam int P  = PAGE_INDEX_BITS;
    localparam int LW = PAGE_INDEX_BITS + 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int WW = P + LW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    logic [WW-1:0] mem [MAX_EXTENTS];

    logic [1:0]    cmd_reg;
    logic [P-1:0]  s_reg,     s_next;
    logic [LW-1:0] len_reg,   len_next;
    logic [LW-1:0] n_reg,     n_next;
    logic [CW-1:0] idx_reg,   idx_next;
    logic [CW-1:0] jdx_reg,   jdx_next;
    logic [CW-1:0] kept_reg,  kept_next;
    logic [CW-1:0] used_reg,  used_next;
    logic [LW-1:0] free_reg,  free_next;
    logic [1:0]    stat_reg,  stat_next;
    logic [P-1:0]  block_reg, block_next;
    logic [WW-1:0] rd_q;

    logic          rd_en;
    logic [CW-1:0] rd_addr;
    logic          we;
    logic [CW-1:0] waddr;
    logic [WW-1:0] wdata;

    logic [P-1:0]  es;
    logic [LW-1:0] el;
    logic [P+1:0]  blk_end;
    logic [P+1:0]  ext_end;
    logic [LW:0]   len_sum;
    logic [LW-1:0] len_sat;
    logic [LW:0]   free_sum;
    logic [LW-1:0] free_sat;
    logic          hit;

    assign es       = rd_q[WW-1:LW];
    assign el       = rd_q[LW-1:0];
    assign blk_end  = {2'b00, s_reg} + {1'b0, len_reg};
    assign ext_end  = {2'b00, es} + {1'b0, el};
    assign len_sum  = {1'b0, len_reg} + {1'b0, el};
    assign len_sat  = len_sum[LW] ? {LW{1'b1}} : len_sum[LW-1:0];
    assign free_sum = {1'b0, free_reg} + {1'b0, n_reg};
    assign free_sat = free_sum[LW] ? {LW{1'b1}} : free_sum[LW-1:0];

    always_comb
    begin
        unique case (cmd_reg)
            CMD_ADD:   hit = (es > s_reg);
            CMD_ALLOC: hit = (el >= n_reg);
            default:   hit = (blk_end <= {2'b00, es});
        endcase
    end

    assign stat.cmd        = cmd_reg;
    assign stat.cnt_zero   = (n_reg == '0) || (cmd_reg != CMD_ADD && cmd_reg != CMD_ALLOC
                                               && cmd_reg != CMD_FREE);
    assign stat.table_full = (used_reg >= MAX_CNT);
    assign stat.over_free  = (n_reg > free_reg);
    assign stat.idx_end    = (idx_reg == used_reg);
    assign stat.j_at_pos   = (jdx_reg == idx_reg);
    assign stat.j_last     = ((jdx_reg + ONE) == used_reg);
    assign stat.hit        = hit;
    assign stat.exact      = (el == n_reg);
    assign stat.kept_full  = (kept_reg >= MAX_CNT);

    always_comb
    begin
        s_next     = s_reg;
        len_next   = len_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        jdx_next   = jdx_reg;
        kept_next  = kept_reg;
        used_next  = used_reg;
        free_next  = free_reg;
        stat_next  = stat_reg;
        block_next = block_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        we         = 1'b0;
        waddr      = jdx_reg;
        wdata      = rd_q;
        unique case (ctl.op)
            OP_LOAD:
            begin
                s_next     = page_index;
                len_next   = page_count;
                n_next     = page_count;
                idx_next   = '0;
                kept_next  = '0;
                stat_next  = ST_OK;
                block_next = '0;
            end
            OP_NEXT:
            begin
                idx_next = idx_reg + ONE;
            end
            OP_RD_IDX:
            begin
                rd_en = 1'b1;
            end
            OP_RD_JM1:
            begin
                rd_en   = 1'b1;
                rd_addr = jdx_reg - ONE;
            end
            OP_RD_JP1:
            begin
                rd_en   = 1'b1;
                rd_addr = jdx_reg + ONE;
            end
            OP_SHINIT:
            begin
                jdx_next = used_reg;
            end
            OP_SHD:
            begin
                we       = 1'b1;
                jdx_next = jdx_reg - ONE;
            end
            OP_SHU:
            begin
                we       = 1'b1;
                jdx_next = jdx_reg + ONE;
            end
            OP_INS:
            begin
                we        = 1'b1;
                waddr     = idx_reg;
                wdata     = {s_reg, len_reg};
                used_next = used_reg + ONE;
                free_next = free_sat;
            end
            OP_AEV:
            begin
                if (hit)
                begin
                    block_next = es;
                    free_next  = free_reg - n_reg;
                    jdx_next   = idx_reg;
                    if (el != n_reg)
                    begin
                        we    = 1'b1;
                        waddr = idx_reg;
                        wdata = {P'({1'b0, es} + n_reg), el - n_reg};
                    end
                end
                else
                begin
                    idx_next = idx_reg + ONE;
                end
            end
            OP_REMEND:
            begin
                used_next = used_reg - ONE;
            end
            OP_MEV:
            begin
                idx_next = idx_reg + ONE;
                if (blk_end == {2'b00, es})
                begin
                    len_next = len_sat;
                end
                else if (ext_end == {2'b00, s_reg})
                begin
                    s_next   = es;
                    len_next = len_sat;
                end
                else
                begin
                    we        = 1'b1;
                    waddr     = kept_reg;
                    kept_next = kept_reg + ONE;
                end
            end
            OP_MEND:
            begin
                used_next = kept_reg;
                idx_next  = '0;
            end
            OP_FULL:
            begin
                stat_next = ST_FULL;
            end
            OP_NOFIT:
            begin
                stat_next = ST_NOFIT;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= '0;
            idx_reg   <= '0;
            jdx_reg   <= '0;
            kept_reg  <= '0;
            used_reg  <= '0;
            free_reg  <= '0;
            stat_reg  <= ST_OK;
        end
        else
        begin
            if (ctl.op == OP_LOAD)
            begin
                cmd_reg <= cmd;
            end
            idx_reg  <= idx_next;
            jdx_reg  <= jdx_next;
            kept_reg <= kept_next;
            used_reg <= used_next;
            free_reg <= free_next;
            stat_reg <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        len_reg   <= len_next;
        n_reg     <= n_next;
        block_reg <= block_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr[AW-1:0]] <= wdata;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr[AW-1:0]];
        end
    end

    assign status      = stat_reg;
    assign block_start = block_reg;
    assign free_total  = free_reg;

endmodule

[rtl/first_fit_page_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit page allocator over an address-ordered table of free extents.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  command  start / busy       cmd, page_index, page_count
//  result   done (one cycle)   status, block_start, free_total
//
//  An item scans the table for the target entry, then shifts entries to
//  insert or remove one, all through the single-port extent memory (read
//  data registered). A new command is taken only while busy is low. Reset
//  empties the table at once; no clearing pass. busy stays high until the
//  cycle after done; the receiver cannot stall a result.
// ----------------------------------------------------------------------------
module first_fit_page_allocator #(
    parameter int MAX_EXTENTS     = ffpa_pkg::MAX_EXTENTS_DEF,
    parameter int PAGE_INDEX_BITS = ffpa_pkg::PAGE_INDEX_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 cmd,
    input  logic [PAGE_INDEX_BITS-1:0] page_index,
    input  logic [PAGE_INDEX_BITS:0]   page_count,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [PAGE_INDEX_BITS-1:0] block_start,
    output logic [PAGE_INDEX_BITS:0]   free_total
);
    import ffpa_pkg::*;

    dp_ctl_t  ctl;
    dp_stat_t stat;

    ffpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .ctl   (ctl)
    );

    ffpa_dp #(
        .MAX_EXTENTS     (MAX_EXTENTS),
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .page_index  (page_index),
        .page_count  (page_count),
        .ctl         (ctl),
        .stat        (stat),
        .status      (status),
        .block_start (block_start),
        .free_total  (free_total)
    );

endmodule

[bench/ffpa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_checker
// Watches the command and result channels of the first-fit page allocator.
// Each accepted command is applied to a local copy of the extent table and
// free count. The expected status, block start and free total are queued
// and compared field by field with each result strobe.
// ----------------------------------------------------------------------------
module ffpa_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  cmd,
    input  logic [19:0] page_index,
    input  logic [20:0] page_count,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [19:0] block_start,
    input  logic [20:0] free_total,
    output int          errors,
    output int          pending
);
    import ffpa_pkg::*;

    localparam int          N_EXT   = 64;
    localparam logic [21:0] LEN_MAX = 22'h1FFFFF;

    typedef struct packed {
        logic [1:0]  st;
        logic [19:0] blk;
        logic [20:0] total;
    } outcome_t;

    outcome_t    outcome_q[$];
    logic [19:0] ext_start[N_EXT];
    logic [20:0] ext_len[N_EXT];
    logic [19:0] keep_start[N_EXT];
    logic [20:0] keep_len[N_EXT];
    int          ext_used;
    logic [20:0] pages_free;

    function automatic logic [21:0] sat_sum(logic [21:0] a, logic [21:0] b);
        logic [22:0] s;
        s = a + b;
        return (s > LEN_MAX) ? LEN_MAX : s[21:0];
    endfunction

    task automatic place_extent(int pos, logic [19:0] s, logic [20:0] len);
        for (int i = ext_used; i > pos; i--)
        begin
            ext_start[i] = ext_start[i-1];
            ext_len[i]   = ext_len[i-1];
        end
        ext_start[pos] = s;
        ext_len[pos]   = len;
        ext_used++;
    endtask

    task automatic apply_command(logic [1:0] c, logic [19:0] idx, logic [20:0] cnt,
                                 output outcome_t o);
        logic [21:0] s;
        logic [21:0] len;
        int          pos;
        int          kept;
        o = '0;
        if (cnt != 0)
        begin
            if (c == CMD_ADD)
            begin
                if (ext_used >= N_EXT)
                    o.st = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < ext_used && ext_start[pos] <= idx)
                        pos++;
                    place_extent(pos, idx, cnt);
                    pages_free = 21'(sat_sum({1'b0, pages_free}, {1'b0, cnt}));
                end
            end
            else if (c == CMD_ALLOC)
            begin
                o.st = ST_NOFIT;
                if (cnt <= pages_free)
                begin
                    for (int i = 0; i < ext_used; i++)
                    begin
                        if (ext_len[i] >= cnt)
                        begin
                            o.st  = ST_OK;
                            o.blk = ext_start[i];
                            if (ext_len[i] > cnt)
                            begin
                                ext_start[i] = ext_start[i] + cnt[19:0];
                                ext_len[i]   = ext_len[i] - cnt;
                            end
                            else
                            begin
                                for (int j = i; j + 1 < ext_used; j++)
                                begin
                                    ext_start[j] = ext_start[j+1];
                                    ext_len[j]   = ext_len[j+1];
                                end
                                ext_used--;
                            end
                            pages_free = pages_free - cnt;
                            break;
                        end
                    end
                end
            end
            else if (c == CMD_FREE)
            begin
                s    = {2'b0, idx};
                len  = {1'b0, cnt};
                kept = 0;
                for (int i = 0; i < ext_used; i++)
                begin
                    if (s + len == {2'b0, ext_start[i]})
                        len = sat_sum(len, {1'b0, ext_len[i]});
                    else if ({2'b0, ext_start[i]} + ext_len[i] == s)
                    begin
                        s   = {2'b0, ext_start[i]};
                        len = sat_sum(len, {1'b0, ext_len[i]});
                    end
                    else
                    begin
                        keep_start[kept] = ext_start[i];
                        keep_len[kept]   = ext_len[i];
                        kept++;
                    end
                end
                if (kept >= N_EXT)
                    o.st = ST_FULL;
                else
                begin
                    for (int i = 0; i < kept; i++)
                    begin
                        ext_start[i] = keep_start[i];
                        ext_len[i]   = keep_len[i];
                    end
                    ext_used = kept;
                    pos = 0;
                    while (pos < ext_used && s + len > {2'b0, ext_start[pos]})
                        pos++;
                    place_extent(pos, s[19:0], len[20:0]);
                    pages_free = 21'(sat_sum({1'b0, pages_free}, {1'b0, cnt}));
                end
            end
        end
        o.total = pages_free;
    endtask

    assign pending = outcome_q.size();

    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            errors     = 0;
            ext_used   = 0;
            pages_free = '0;
            outcome_q.delete();
        end
        else
        begin
            if (done)
            begin
                got = '{status, block_start, free_total};
                if (outcome_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result with no command outstanding", $realtime);
                    errors++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                            $display("%0t: mismatch status %0d/%0d start %h/%h total %h/%h",
                                     $realtime, want.st, got.st, want.blk, got.blk,
                                     want.total, got.total);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                apply_command(cmd, page_index, page_count, want);
                outcome_q.push_back(want);
            end
        end
    end
endmodule

[bench/tb_first_fit_page_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_page_allocator
// Drives directed then random add, allocate and free commands into the
// page allocator with random or no gaps, and gives the verdict from the checker's
// mismatch count. A watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
module tb_first_fit_page_allocator;
    import ffpa_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int         STALL_LIMIT = 4000;
    localparam int         N_RANDOM    = 850;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [19:0] page_index;
    logic [20:0] page_count;
    logic        done;
    logic [1:0]  status;
    logic [19:0] block_start;
    logic [20:0] free_total;
    int          errors;
    int          pending;
    int          idle_cycles;
    bit          no_gaps;

    first_fit_page_allocator u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .page_index(page_index), .page_count(page_count), .done(done),
        .status(status), .block_start(block_start), .free_total(free_total)
    );

    ffpa_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .page_index(page_index), .page_count(page_count), .done(done),
        .status(status), .block_start(block_start), .free_total(free_total),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic issue(logic [1:0] c, logic [19:0] idx, logic [20:0] cnt);
        int gap;
        gap = 0;
        if (!no_gaps)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                               : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      = 1'b1;
        cmd        = c;
        page_index = idx;
        page_count = cnt;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int          r;
        logic [1:0]  c;
        logic [19:0] idx;
        logic [20:0] cnt;
        no_gaps    = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = CMD_ADD;
        page_index = '0;
        page_count = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        issue(CMD_UNKNOWN, 20'hFFFFF, 21'd5);
        issue(CMD_ADD,     20'd100,   21'd0);
        issue(CMD_ALLOC,   20'd0,     21'd1);
        issue(CMD_ADD,     20'd100,   21'd10);
        issue(CMD_ADD,     20'hFFFF0, 21'h100);
        issue(CMD_ADD,     20'd50,    21'd5);
        issue(CMD_ALLOC,   20'd0,     21'd11);
        issue(CMD_ALLOC,   20'd0,     21'h20);
        issue(CMD_ALLOC,   20'd0,     21'd5);
        issue(CMD_FREE,    20'd50,    21'd5);
        issue(CMD_FREE,    20'd55,    21'd45);
        issue(CMD_FREE,    20'd0,     21'd0);
        issue(CMD_ALLOC,   20'd0,     21'h1FFFFF);
        issue(CMD_ADD,     20'd0,     21'h1FFFFF);
        issue(CMD_FREE,    20'hFFFFF, 21'h100000);
        issue(CMD_ALLOC,   20'd0,     21'h1FFFFF);
        issue(CMD_ALLOC,   20'd0,     21'h100000);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 100 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            c = (r < 35) ? CMD_ADD : (r < 65) ? CMD_ALLOC : (r < 97) ? CMD_FREE : CMD_UNKNOWN;
            idx = ($urandom_range(0, 99) < 85) ? 20'($urandom_range(0, 2047)) : 20'($urandom);
            r = $urandom_range(0, 99);
            if (r < 80)
                cnt = 21'($urandom_range(1, 32));
            else if (r < 92)
                cnt = 21'($urandom_range(0, 4095));
            else if (r < 97)
                cnt = 21'($urandom);
            else
                cnt = '0;
            issue(c, idx, cnt);
        end
        start = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (done || (start && !busy) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end
endmodule
